/* design/assert_macros.svh */
// Concurrent assertion wrappers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PHUD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PHUD_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define PHUD_ASSERT(lbl, clk, rst_n, prop)
`define PHUD_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

/* design/phud_pkg.sv */
`default_nettype none
package phud_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned PREFIX_LEN = 3;

    localparam logic [CHAR_W-1:0] CHR_V    = 8'h76;
    localparam logic [CHAR_W-1:0] CHR_ONE  = 8'h31;
    localparam logic [CHAR_W-1:0] CHR_DASH = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_9    = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_F    = 8'h66;
    localparam logic [3:0]        HEX_A_OFFSET = 4'd9;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_PREFIX = 3'd1,
        ST_ODD    = 3'd2,
        ST_DIGIT  = 3'd3,
        ST_ZERO   = 3'd4,
        ST_UTF8   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        RNG_ANY   = 3'd0,
        RNG_A0_BF = 3'd1,
        RNG_80_9F = 3'd2,
        RNG_90_BF = 3'd3,
        RNG_80_8F = 3'd4
    } t_range;

    typedef struct packed {
        logic [1:0] prefix_pos;
        logic [3:0] high_nibble;
        logic       pending;
        logic [1:0] utf8_left;
        t_range     utf8_range;
        t_status    err;
    } t_state;

    localparam t_state STATE_RESET = '{
        prefix_pos:  2'd0,
        high_nibble: 4'd0,
        pending:     1'b0,
        utf8_left:   2'd0,
        utf8_range:  RNG_ANY,
        err:         ST_OK
    };

    typedef struct packed {
        logic               valid;
        logic [CHAR_W-1:0]  value_byte;
        logic               byte_present;
        logic               is_final;
        t_status            status;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [1:0] left;
        t_range     range;
    } t_utf8;

    function automatic logic [CHAR_W-1:0] prefix_char(input logic [1:0] pos);
        logic [CHAR_W-1:0] c;
        unique case (pos)
            2'd0:    c = CHR_V;
            2'd1:    c = CHR_ONE;
            default: c = CHR_DASH;
        endcase
        return c;
    endfunction

    function automatic t_status note_err(input t_status cur, input t_status e);
        if (cur == ST_OK || (cur == ST_UTF8 && (e == ST_DIGIT || e == ST_ZERO))) begin
            return e;
        end
        return cur;
    endfunction

    function automatic t_utf8 utf8_check(input logic [1:0] left, input t_range range,
                                         input logic [CHAR_W-1:0] b);
        t_utf8             r;
        logic [CHAR_W-1:0] lo;
        logic [CHAR_W-1:0] hi;
        r  = '{ok: 1'b1, left: 2'd0, range: RNG_ANY};
        lo = 8'h80;
        hi = 8'hBF;
        if (left != 2'd0) begin
            unique case (range)
                RNG_A0_BF: lo = 8'hA0;
                RNG_80_9F: hi = 8'h9F;
                RNG_90_BF: lo = 8'h90;
                RNG_80_8F: hi = 8'h8F;
                default:   lo = 8'h80;
            endcase
            r.ok   = (b >= lo) && (b <= hi);
            r.left = left - 2'd1;
        end else begin
            priority if (b < 8'h80) begin
                r.left = 2'd0;
            end else if (b >= 8'hC2 && b <= 8'hDF) begin
                r.left = 2'd1;
            end else if (b == 8'hE0) begin
                r.left = 2'd2; r.range = RNG_A0_BF;
            end else if (b == 8'hED) begin
                r.left = 2'd2; r.range = RNG_80_9F;
            end else if (b >= 8'hE1 && b <= 8'hEF) begin
                r.left = 2'd2;
            end else if (b == 8'hF0) begin
                r.left = 2'd3; r.range = RNG_90_BF;
            end else if (b >= 8'hF1 && b <= 8'hF3) begin
                r.left = 2'd3;
            end else if (b == 8'hF4) begin
                r.left = 2'd3; r.range = RNG_80_8F;
            end else begin
                r.ok = 1'b0;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/phud_if.sv */
`default_nettype none
interface phud_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface phud_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] value_byte;
    logic       byte_present;
    logic       is_final;
    logic [2:0] status;

    modport source (output valid, output value_byte, output byte_present,
                    output is_final, output status, input ready);
    modport sink   (input valid, input value_byte, input byte_present,
                    input is_final, input status, output ready);
endinterface
`default_nettype wire

/* design/phud_step.sv */
`default_nettype none
module phud_step import phud_pkg::*; (
    input  t_state            i_state,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_end,
    output t_state            o_next,
    output t_result           o_res
);

    logic              is_dec;
    logic              is_hex;
    logic [3:0]        digit;
    logic              have;
    logic [CHAR_W-1:0] byte_val;
    t_utf8             chk;
    t_state            n_state;
    t_status           fin_status;

    assign is_dec = (i_char_code >= CHR_0) && (i_char_code <= CHR_9);
    assign is_hex = (i_char_code >= CHR_A) && (i_char_code <= CHR_F);
    assign digit  = is_dec ? i_char_code[3:0] : i_char_code[3:0] + HEX_A_OFFSET;
    assign chk    = utf8_check(i_state.utf8_left, i_state.utf8_range,
                               {i_state.high_nibble, digit});

    always_comb begin
        n_state  = i_state;
        have     = 1'b0;
        byte_val = '0;
        if (i_state.prefix_pos < 2'(PREFIX_LEN)) begin
            if (i_state.err == ST_OK) begin
                if (i_char_code != prefix_char(i_state.prefix_pos)) begin
                    n_state.err = ST_PREFIX;
                end else begin
                    n_state.prefix_pos = i_state.prefix_pos + 2'd1;
                end
            end
        end else if (!i_state.pending) begin
            n_state.pending = 1'b1;
            if (!(is_dec || is_hex)) begin
                n_state.err = note_err(i_state.err, ST_DIGIT);
            end else begin
                n_state.high_nibble = digit;
            end
        end else begin
            n_state.pending = 1'b0;
            priority if (!(is_dec || is_hex)) begin
                n_state.err = note_err(i_state.err, ST_DIGIT);
            end else if (i_state.high_nibble == 4'd0 && digit == 4'd0) begin
                n_state.err = note_err(i_state.err, ST_ZERO);
            end else if (i_state.err == ST_OK) begin
                byte_val = {i_state.high_nibble, digit};
                if (chk.ok) begin
                    have               = 1'b1;
                    n_state.utf8_left  = chk.left;
                    n_state.utf8_range = chk.range;
                end else begin
                    n_state.err = ST_UTF8;
                end
            end else begin
                n_state.err = i_state.err;
            end
        end
    end

    always_comb begin
        fin_status = n_state.err;
        priority if (n_state.err == ST_OK && n_state.prefix_pos < 2'(PREFIX_LEN)) begin
            fin_status = ST_PREFIX;
        end else if (n_state.err != ST_PREFIX && n_state.prefix_pos == 2'(PREFIX_LEN)
                     && n_state.pending) begin
            fin_status = ST_ODD;
        end else if (n_state.err == ST_OK && n_state.utf8_left != 2'd0) begin
            fin_status = ST_UTF8;
        end else begin
            fin_status = n_state.err;
        end
    end

    always_comb begin
        o_res.valid        = i_end || have;
        o_res.is_final     = i_end;
        o_res.status       = i_end ? fin_status : ST_OK;
        o_res.byte_present = have && (!i_end || fin_status == ST_OK);
        o_res.value_byte   = o_res.byte_present ? byte_val : '0;
        o_next             = i_end ? STATE_RESET : n_state;
    end

endmodule
`default_nettype wire

/* design/prefixed_hex_utf8_decoder_top.sv */
`default_nettype none
// Channel   Direction  Payload
// i_char    in         char_code[7:0], end_of_string
// o_res     out        value_byte[7:0], byte_present, is_final, status[2:0]
//
// One character is taken per cycle unless a held result stalls; its result, if any, appears in the next cycle.
// The decode state and the result register update at the same edge.
// Reset is synchronous and returns the block to the start of a string.
// A stalled result holds; a new character is still taken in the cycle the result leaves.
`include "assert_macros.svh"
module prefixed_hex_utf8_decoder_top import phud_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    phud_char_if.sink i_char,
    phud_res_if.source o_res
);

    t_state  r_state;
    t_state  n_state;
    t_result n_res;
    logic    r_out_valid;
    logic [CHAR_W-1:0] r_value_byte;
    logic    r_byte_present;
    logic    r_is_final;
    t_status r_status;
    logic    in_acc;

    phud_step u_step (
        .i_state     (r_state),
        .i_char_code (i_char.char_code),
        .i_end       (i_char.end_of_string),
        .o_next      (n_state),
        .o_res       (n_res)
    );

    assign i_char.ready = !r_out_valid || o_res.ready;
    assign in_acc       = i_char.valid && i_char.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_state     <= n_state;
            r_out_valid <= n_res.valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_res.valid) begin
            r_value_byte   <= n_res.value_byte;
            r_byte_present <= n_res.byte_present;
            r_is_final     <= n_res.is_final;
            r_status       <= n_res.status;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.value_byte   = r_value_byte;
    assign o_res.byte_present = r_byte_present;
    assign o_res.is_final     = r_is_final;
    assign o_res.status       = r_status;

    `PHUD_ASSERT(a_mid_has_byte, i_clk, i_rst_n, r_out_valid && !r_is_final |-> r_byte_present && r_status == ST_OK)
    `PHUD_ASSERT(a_byte_only_ok, i_clk, i_rst_n, r_out_valid && r_byte_present |-> r_status == ST_OK)
    `PHUD_ASSERT(a_end_clears, i_clk, i_rst_n, in_acc && i_char.end_of_string |=> r_state == STATE_RESET)

endmodule
`default_nettype wire

/* bench/prefixed_hex_utf8_decoder_top_tb.sv */
`timescale 1ns / 100ps
module prefixed_hex_utf8_decoder_top_tb;
    import phud_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned TARGET_CHARS = 1550;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned LONG_STALL   = 300;
    localparam int unsigned SETTLE       = 20;

    typedef struct {
        logic [7:0] code;
        logic       last;
        bit         drain_first;
    } char_item_t;

    typedef struct {
        logic [7:0] value_byte;
        logic       byte_present;
        logic       is_final;
        t_status    status;
    } decode_out_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    phud_char_if chr_if ();
    phud_res_if  res_if ();

    prefixed_hex_utf8_decoder_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (chr_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    char_item_t  pending_chars[$];
    decode_out_t expected_results[$];
    logic [7:0]  str_buf[$];

    int unsigned chars_accepted = 0;
    int unsigned chars_offered  = 0;
    int unsigned results_taken  = 0;
    int unsigned results_noted  = 0;
    int unsigned cycle_count    = 0;
    int unsigned mismatches     = 0;

    int send_wait   = 0;
    int send_burst  = 0;
    int recv_wait   = 0;
    int recv_burst  = 0;
    int stall_left  = 0;
    bit stall_done  = 1'b0;

    // Decoder state as the checker tracks it.
    int unsigned pfx_matched;
    logic [3:0]  hi_digit;
    logic        digit_waiting;
    logic [1:0]  cont_left;
    t_range      cont_range;
    t_status     held_status;

    function automatic void clear_decoder();
        pfx_matched   = 0;
        hi_digit      = 4'h0;
        digit_waiting = 1'b0;
        cont_left     = 2'd0;
        cont_range    = RNG_ANY;
        held_status   = ST_OK;
    endfunction

    function automatic int hex_value(input logic [7:0] ch);
        if (ch >= CHR_0 && ch <= CHR_9) begin
            return int'(ch - CHR_0);
        end
        if (ch >= CHR_A && ch <= CHR_F) begin
            return 10 + int'(ch - CHR_A);
        end
        return -1;
    endfunction

    // A digit or zero-pair fault overrides an earlier UTF-8 fault.
    function automatic void record_error(input t_status e);
        if (held_status == ST_OK ||
            (held_status == ST_UTF8 && (e == ST_DIGIT || e == ST_ZERO))) begin
            held_status = e;
        end
    endfunction

    function automatic bit utf8_take(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hbf;
        if (cont_left != 2'd0) begin
            case (cont_range)
                RNG_A0_BF: lo = 8'ha0;
                RNG_80_9F: hi = 8'h9f;
                RNG_90_BF: lo = 8'h90;
                RNG_80_8F: hi = 8'h8f;
                default: ;
            endcase
            if (b < lo || b > hi) begin
                return 1'b0;
            end
            cont_left  = cont_left - 2'd1;
            cont_range = RNG_ANY;
            return 1'b1;
        end
        if (b < 8'h80) begin
            return 1'b1;
        end
        if (b >= 8'hc2 && b <= 8'hdf) begin
            cont_left = 2'd1; cont_range = RNG_ANY;
        end else if (b == 8'he0) begin
            cont_left = 2'd2; cont_range = RNG_A0_BF;
        end else if (b == 8'hed) begin
            cont_left = 2'd2; cont_range = RNG_80_9F;
        end else if (b >= 8'he1 && b <= 8'hef) begin
            cont_left = 2'd2; cont_range = RNG_ANY;
        end else if (b == 8'hf0) begin
            cont_left = 2'd3; cont_range = RNG_90_BF;
        end else if (b >= 8'hf1 && b <= 8'hf3) begin
            cont_left = 2'd3; cont_range = RNG_ANY;
        end else if (b == 8'hf4) begin
            cont_left = 2'd3; cont_range = RNG_80_8F;
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit decode_char(input logic [7:0] ch, input logic last,
                                       output decode_out_t r);
        int         v;
        bit         got;
        logic [7:0] b;
        logic [7:0] want;
        t_status    st;
        got = 1'b0;
        b   = 8'h00;
        r   = '{value_byte: 8'h00, byte_present: 1'b0, is_final: 1'b0, status: ST_OK};
        if (pfx_matched < PREFIX_LEN) begin
            want = (pfx_matched == 0) ? CHR_V : (pfx_matched == 1) ? CHR_ONE : CHR_DASH;
            if (held_status == ST_OK) begin
                if (ch != want) begin
                    held_status = ST_PREFIX;
                end else begin
                    pfx_matched++;
                end
            end
        end else begin
            v = hex_value(ch);
            if (!digit_waiting) begin
                digit_waiting = 1'b1;
                if (v < 0) begin
                    record_error(ST_DIGIT);
                end else begin
                    hi_digit = v[3:0];
                end
            end else begin
                digit_waiting = 1'b0;
                if (v < 0) begin
                    record_error(ST_DIGIT);
                end else if (hi_digit == 4'h0 && v == 0) begin
                    record_error(ST_ZERO);
                end else if (held_status == ST_OK) begin
                    b = {hi_digit, v[3:0]};
                    if (utf8_take(b)) begin
                        got = 1'b1;
                    end else begin
                        record_error(ST_UTF8);
                    end
                end
            end
        end
        if (!last) begin
            r.value_byte   = b;
            r.byte_present = 1'b1;
            return got;
        end
        st = held_status;
        if (st == ST_OK && pfx_matched < PREFIX_LEN) begin
            st = ST_PREFIX;
        end else if (st != ST_PREFIX && pfx_matched >= PREFIX_LEN && digit_waiting) begin
            st = ST_ODD;
        end else if (st == ST_OK && cont_left != 2'd0) begin
            st = ST_UTF8;
        end
        got            = got && (st == ST_OK);
        r.value_byte   = got ? b : 8'h00;
        r.byte_present = got;
        r.is_final     = 1'b1;
        r.status       = st;
        clear_decoder();
        return 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? CHR_0 + {4'h0, n} : CHR_A + {4'h0, n} - 8'd10;
    endfunction

    function automatic void push_hex(input logic [7:0] b);
        str_buf.push_back(hex_char(b[7:4]));
        str_buf.push_back(hex_char(b[3:0]));
    endfunction

    function automatic void push_prefix();
        str_buf.push_back(CHR_V);
        str_buf.push_back(CHR_ONE);
        str_buf.push_back(CHR_DASH);
    endfunction

    function automatic logic [7:0] cont_byte(input int unsigned bits);
        return 8'h80 | 8'(bits & 'h3f);
    endfunction

    function automatic void add_codepoint();
        int unsigned cp;
        case ($urandom_range(0, 4))
            0: cp = $urandom_range(1, 'h7f);
            1: cp = $urandom_range('h80, 'h7ff);
            2: begin
                cp = $urandom_range('h800, 'hffff);
                if (cp >= 'hd800 && cp <= 'hdfff) begin
                    cp = cp - 'h800;
                end
            end
            3: cp = $urandom_range('h10000, 'h10ffff);
            default: begin
                case ($urandom_range(0, 9))
                    0: cp = 'h1;
                    1: cp = 'h7f;
                    2: cp = 'h80;
                    3: cp = 'h7ff;
                    4: cp = 'h800;
                    5: cp = 'hd7ff;
                    6: cp = 'he000;
                    7: cp = 'hffff;
                    8: cp = 'h10000;
                    default: cp = 'h10ffff;
                endcase
            end
        endcase
        if (cp < 'h80) begin
            push_hex(8'(cp));
        end else if (cp < 'h800) begin
            push_hex(8'hc0 | 8'(cp >> 6));
            push_hex(cont_byte(cp));
        end else if (cp < 'h10000) begin
            push_hex(8'he0 | 8'(cp >> 12));
            push_hex(cont_byte(cp >> 6));
            push_hex(cont_byte(cp));
        end else begin
            push_hex(8'hf0 | 8'(cp >> 18));
            push_hex(cont_byte(cp >> 12));
            push_hex(cont_byte(cp >> 6));
            push_hex(cont_byte(cp));
        end
    endfunction

    function automatic void add_bad_sequence();
        case ($urandom_range(0, 9))
            0: push_hex(8'hc0);
            1: push_hex(8'hc1);
            2: push_hex(8'($urandom_range('hf5, 'hff)));
            3: push_hex(8'($urandom_range('h80, 'hbf)));
            4: begin
                push_hex(8'he0);
                push_hex(8'($urandom_range('h80, 'h9f)));
            end
            5: begin
                push_hex(8'hed);
                push_hex(8'($urandom_range('ha0, 'hbf)));
            end
            6: begin
                push_hex(8'hf0);
                push_hex(8'($urandom_range('h80, 'h8f)));
            end
            7: begin
                push_hex(8'hf4);
                push_hex(8'($urandom_range('h90, 'hbf)));
            end
            8: push_hex(8'($urandom_range('hc2, 'hf4)));
            default: begin
                push_hex(8'($urandom_range('he1, 'hef)));
                push_hex(8'($urandom_range('h01, 'h7f)));
            end
        endcase
    endfunction

    function automatic void build_encoded_string();
        int n;
        int kind;
        int slot;
        int j;
        str_buf.delete();
        push_prefix();
        n    = $urandom_range(0, 5);
        kind = $urandom_range(0, 99);
        slot = $urandom_range(0, n);
        for (j = 0; j <= n; j++) begin
            if (j == slot && kind >= 70 && kind < 76) begin
                push_hex(8'h00);
            end
            if (j == slot && kind >= 76 && kind < 86) begin
                add_bad_sequence();
            end
            if (j < n) begin
                add_codepoint();
            end
        end
        if (kind >= 86 && kind < 91) begin
            str_buf[$urandom_range(0, str_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (kind >= 91 && kind < 95) begin
            str_buf.delete($urandom_range(0, str_buf.size() - 1));
        end else if (kind >= 95 && kind < 98) begin
            repeat ($urandom_range(1, 2)) begin
                if (str_buf.size() > 1) begin
                    void'(str_buf.pop_back());
                end
            end
        end else if (kind >= 98) begin
            str_buf[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
        end
    endfunction

    function automatic void build_noise_string();
        str_buf.delete();
        if ($urandom_range(0, 1) == 0) begin
            push_prefix();
        end
        repeat ($urandom_range(1, 6)) begin
            str_buf.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void queue_string(input bit drain);
        int i;
        for (i = 0; i < str_buf.size(); i++) begin
            pending_chars.push_back('{code: str_buf[i], last: (i == str_buf.size() - 1),
                                      drain_first: (drain && i == 0)});
        end
    endfunction

    function automatic void queue_text(input string s);
        int i;
        str_buf.delete();
        for (i = 0; i < s.len(); i++) begin
            str_buf.push_back(s[i]);
        end
        queue_string(1'b0);
    endfunction

    function automatic int pick_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic flag_result(input string what, input decode_out_t want);
        if (mismatches < MAX_REPORTS) begin
            $display("%0t: %s: expected byte %02h present %0b final %0b status %0d, got byte %02h present %0b final %0b status %0d",
                     $time, what, want.value_byte, want.byte_present, want.is_final,
                     want.status, res_if.value_byte, res_if.byte_present,
                     res_if.is_final, res_if.status);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin : monitor
        decode_out_t want;
        decode_out_t fresh;
        if (i_rst_n) begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                if (res_if.valid && res_if.ready) begin
                    results_taken++;
                    if (expected_results.size() == 0) begin
                        want = '{value_byte: 8'h00, byte_present: 1'b0, is_final: 1'b0,
                                 status: ST_OK};
                        flag_result("transaction with none expected", want);
                    end else begin
                        want = expected_results.pop_front();
                        if (res_if.value_byte !== want.value_byte ||
                            res_if.byte_present !== want.byte_present ||
                            res_if.is_final !== want.is_final ||
                            res_if.status !== want.status) begin
                            flag_result("mismatch", want);
                        end
                    end
                end
                if (chr_if.valid && chr_if.ready) begin
                    chars_accepted++;
                    if (decode_char(chr_if.char_code, chr_if.end_of_string, fresh)) begin
                        expected_results.push_back(fresh);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin : driver
        char_item_t item;
        logic       offer;
        if (i_rst_n) begin
            offer = chr_if.valid;
            if (chr_if.valid && chars_accepted == chars_offered) begin
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_chars.size() != 0 &&
                             !(pending_chars[0].drain_first && expected_results.size() != 0)) begin
                    item = pending_chars.pop_front();
                    chr_if.char_code     <= item.code;
                    chr_if.end_of_string <= item.last;
                    offer = 1'b1;
                    chars_offered++;
                    send_wait = pick_gap(send_burst);
                end
            end
            chr_if.valid <= offer;
        end
    end

    always @(negedge i_clk) begin : receiver
        if (i_rst_n) begin
            if (!stall_done && chars_accepted >= 300) begin
                stall_done = 1'b1;
                stall_left = LONG_STALL;
            end
            if (results_taken != results_noted) begin
                results_noted = results_taken;
                recv_wait     = pick_gap(recv_burst);
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int strings;
        chr_if.valid         = 1'b0;
        chr_if.char_code     = 8'h00;
        chr_if.end_of_string = 1'b0;
        res_if.ready         = 1'b0;
        i_rst_n              = 1'b0;
        clear_decoder();

        queue_text("v");
        queue_text("v1-");
        str_buf.delete();
        str_buf.push_back(8'h00);
        queue_string(1'b0);
        queue_text("v1-00");
        queue_text("v1-ff");
        queue_text("v1-e2");
        queue_text("v1-z1");

        strings = 0;
        while (pending_chars.size() < TARGET_CHARS) begin
            if ($urandom_range(0, 6) == 0) begin
                build_noise_string();
            end else begin
                build_encoded_string();
            end
            queue_string(strings == 40 || strings == 150);
            strings++;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_chars.size() != 0 || chr_if.valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/phud_pkg.sv
design/phud_if.sv
design/phud_step.sv
design/prefixed_hex_utf8_decoder_top.sv
bench/prefixed_hex_utf8_decoder_top_tb.sv
